>>> rtl/boa_pkg.sv
// Package for the bus ownership arbiter: sizes, command and status codes,
// the per-bus state entry and the request struct to the state RAM.
// No dependencies.
package boa_pkg;

    localparam int BUS_COUNT       = 8;
    localparam int REQUESTER_COUNT = 8;

    localparam int BUS_AW = (BUS_COUNT > 1) ? $clog2(BUS_COUNT) : 1;
    localparam int REQ_W  = (REQUESTER_COUNT > 1) ? $clog2(REQUESTER_COUNT) : 1;
    localparam int OWN_W  = $clog2(REQUESTER_COUNT + 1);

    localparam logic [4:0] BUS_LIMIT = 5'(BUS_COUNT);
    localparam logic [6:0] REQ_LIMIT = 7'(REQUESTER_COUNT);

    typedef enum logic [2:0] {
        CMD_REQUEST    = 3'd0,
        CMD_RELEASE    = 3'd1,
        CMD_CHECK      = 3'd2,
        CMD_IDLE_QUERY = 3'd3,
        CMD_POLL       = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BUSY  = 2'd1,
        ST_PARAM = 2'd2
    } status_t;

    // Owner code 0 means free, otherwise requester index plus one.
    typedef struct packed {
        logic [OWN_W-1:0]           owner;
        logic [REQUESTER_COUNT-1:0] mask;
    } bus_entry_t;

    typedef struct packed {
        logic              re;
        logic [BUS_AW-1:0] raddr;
        logic              we;
        logic [BUS_AW-1:0] waddr;
        bus_entry_t        wdata;
    } mem_req_t;

    // Index of the highest set bit; zero when the mask is empty.
    function automatic logic [REQ_W-1:0] highest_pending(
        input logic [REQUESTER_COUNT-1:0] mask
    );
        logic [REQ_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < REQUESTER_COUNT; i++)
        begin
            if (mask[i])
            begin
                idx = REQ_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> rtl/boa_state_ram.sv
// Per-bus state RAM of the bus ownership arbiter: one entry per bus,
// synchronous read into an output register, valid bits for reset.
// Depends on boa_pkg.
module boa_state_ram
    import boa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mem_req_t   req,
    output bus_entry_t rd_entry
);

    bus_entry_t             mem [BUS_COUNT];
    logic [BUS_COUNT-1:0]   valid_reg;
    bus_entry_t             rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    // An entry never written since reset reads as a free bus with no waiters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                rd_valid_reg <= valid_reg[req.raddr];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

    a_no_same_entry_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (req.we && req.re) |-> (req.waddr != req.raddr))
        else $error("read and write of the same bus entry in one cycle");

    a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (req.we |-> ({1'b0, 4'(req.waddr)} < BUS_LIMIT)) and
        (req.re |-> ({1'b0, 4'(req.raddr)} < BUS_LIMIT)))
        else $error("state RAM access beyond the bus count");

    a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        req.we |=> valid_reg[$past(req.waddr)])
        else $error("written entry not marked valid");

endmodule

>>> rtl/boa_ctrl.sv
// Command sequencer of the bus ownership arbiter: checks parameters,
// reads a bus entry, applies the command and, for request and release,
// writes it back; a poll sweeps every entry. Depends on boa_pkg.
module boa_ctrl
    import boa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] command,
    input  logic [3:0] bus_id,
    input  logic [5:0] requester,
    input  bus_entry_t rd_entry,
    output mem_req_t   mem_req,
    output logic       busy,
    output logic       done,
    output logic [1:0] status,
    output logic       idle
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_ACCESS = 3'b010,
        S_POLL   = 3'b100
    } state_t;

    localparam logic [BUS_AW-1:0] LAST_BUS = BUS_AW'(BUS_COUNT - 1);

    state_t              state_reg,    state_next;
    cmd_t                cmd_reg,      cmd_next;
    logic [BUS_AW-1:0]   bus_reg,      bus_next;
    logic [REQ_W-1:0]    req_reg,      req_next;
    logic [BUS_AW-1:0]   poll_idx_reg, poll_idx_next;
    logic                done_reg,     done_next;
    status_t             status_reg,   status_next;
    logic                idle_reg,     idle_next;

    logic                       bus_ok;
    logic                       req_ok;
    logic [REQUESTER_COUNT-1:0] req_bit;
    logic [OWN_W-1:0]           req_code;
    logic [REQ_W-1:0]           top_req;
    bus_entry_t                 upd;

    assign bus_ok   = {1'b0, bus_id} < BUS_LIMIT;
    assign req_ok   = {1'b0, requester} < REQ_LIMIT;
    assign req_bit  = REQUESTER_COUNT'(1) << req_reg;
    assign req_code = OWN_W'(req_reg) + OWN_W'(1);
    assign top_req  = highest_pending(rd_entry.mask);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        bus_next      = bus_reg;
        req_next      = req_reg;
        poll_idx_next = poll_idx_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        idle_next     = idle_reg;
        mem_req       = '0;
        upd           = rd_entry;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd_t'(command);
                    bus_next    = bus_id[BUS_AW-1:0];
                    req_next    = requester[REQ_W-1:0];
                    status_next = ST_OK;
                    idle_next   = 1'b0;
                    case (cmd_t'(command))
                        CMD_REQUEST, CMD_RELEASE, CMD_CHECK:
                        begin
                            if (bus_ok && req_ok)
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = bus_id[BUS_AW-1:0];
                                state_next    = S_ACCESS;
                            end
                            else
                            begin
                                status_next = ST_PARAM;
                                done_next   = 1'b1;
                            end
                        end
                        CMD_IDLE_QUERY:
                        begin
                            if (bus_ok)
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = bus_id[BUS_AW-1:0];
                                state_next    = S_ACCESS;
                            end
                            else
                            begin
                                status_next = ST_PARAM;
                                done_next   = 1'b1;
                            end
                        end
                        CMD_POLL:
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = '0;
                            poll_idx_next = '0;
                            state_next    = S_POLL;
                        end
                        default:
                        begin
                            status_next = ST_PARAM;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end

            S_ACCESS:
            begin
                done_next     = 1'b1;
                state_next    = S_IDLE;
                mem_req.waddr = bus_reg;
                case (cmd_reg)
                    CMD_REQUEST:
                    begin
                        if (((rd_entry.mask & ~req_bit) == '0) && (rd_entry.owner == '0))
                        begin
                            upd.owner = req_code;
                            upd.mask  = rd_entry.mask & ~req_bit;
                        end
                        if (upd.owner != req_code)
                        begin
                            upd.mask = upd.mask | req_bit;
                        end
                        mem_req.we    = 1'b1;
                        mem_req.wdata = upd;
                    end
                    CMD_RELEASE:
                    begin
                        upd.mask = rd_entry.mask & ~req_bit;
                        if (rd_entry.owner == req_code)
                        begin
                            upd.owner = '0;
                        end
                        mem_req.we    = 1'b1;
                        mem_req.wdata = upd;
                    end
                    CMD_CHECK:
                    begin
                        status_next = (rd_entry.owner == req_code) ? ST_OK : ST_BUSY;
                    end
                    CMD_IDLE_QUERY:
                    begin
                        idle_next = (rd_entry.mask == '0) && (rd_entry.owner == '0);
                    end
                    default:
                    begin
                        status_next = ST_PARAM;
                    end
                endcase
            end

            S_POLL:
            begin
                // Write back entry i while entry i+1 is being read.
                if ((rd_entry.owner == '0) && (rd_entry.mask != '0))
                begin
                    upd.owner = OWN_W'(top_req) + OWN_W'(1);
                    upd.mask  = rd_entry.mask & ~(REQUESTER_COUNT'(1) << top_req);
                end
                mem_req.we    = 1'b1;
                mem_req.waddr = poll_idx_reg;
                mem_req.wdata = upd;
                if (poll_idx_reg == LAST_BUS)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = poll_idx_reg + BUS_AW'(1);
                    poll_idx_next = poll_idx_reg + BUS_AW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            poll_idx_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            poll_idx_reg <= poll_idx_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        bus_reg    <= bus_next;
        req_reg    <= req_next;
        status_reg <= status_next;
        idle_reg   <= idle_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign idle   = idle_reg;

    a_access_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACCESS) |=> (state_reg == S_IDLE) && done_reg)
        else $error("single-entry access did not finish in one cycle");

    a_poll_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POLL && poll_idx_reg == LAST_BUS) |=>
        (state_reg == S_IDLE) && done_reg)
        else $error("poll sweep did not end after the last bus");

    a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (state_reg != S_IDLE))
        else $error("state write while no item is in progress");

    a_idle_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && idle_reg) |-> (cmd_reg == CMD_IDLE_QUERY) && (status_reg == ST_OK))
        else $error("idle flag raised for a command other than idle query");

endmodule

>>> rtl/bus_ownership_arbiter.sv
// Top level of the bus ownership arbiter: per-bus owner and pending state
// in a RAM, driven by the command sequencer. Depends on boa_pkg,
// boa_state_ram and boa_ctrl.
//
//  Channel   Handshake               Ports
//  command   start & !busy accepts   command, bus_id, requester
//  result    done, one-cycle strobe  status, idle
//
// A parameter error or unknown command gives its result in the cycle after
// the item is taken. Request, release, check ownership and idle query do
// one RAM read, then register the result and, for request and release, write
// back the update. A poll tick sweeps every bus, one RAM entry per cycle,
// with the write-back of one bus overlapping the read of the next.
// Reset marks every bus free with nothing pending; no clearing pass is needed.
// The receiver cannot stall; busy is high while an item is in progress.
module bus_ownership_arbiter
    import boa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] command,
    input  logic [3:0] bus_id,
    input  logic [5:0] requester,
    output logic       done,
    output logic [1:0] status,
    output logic       idle
);

    mem_req_t   mem_req;
    bus_entry_t rd_entry;

    boa_state_ram u_state_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .rd_entry (rd_entry)
    );

    boa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .bus_id    (bus_id),
        .requester (requester),
        .rd_entry  (rd_entry),
        .mem_req   (mem_req),
        .busy      (busy),
        .done      (done),
        .status    (status),
        .idle      (idle)
    );

endmodule
